/* hdl/heater_mister_hysteresis_controller_macros.svh */
// Assertion macros for the heater and mister controller RTL.
`ifndef HEATER_MISTER_HYSTERESIS_CONTROLLER_MACROS_SVH
`define HEATER_MISTER_HYSTERESIS_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every edge outside reset.
`define HMH_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("hmh assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hmh assertion failed");

`else

`define HMH_ASSERT_ALWAYS(label, clk, rst, expr)
`define HMH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/hmh_pkg.sv */
// Types and constants for the heater and mister hysteresis controller.
package hmh_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_TEMPERATURE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_HUMIDITY        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMPERATURE_HYSTERESIS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUMIDITY_HYSTERESIS    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MISTER_ON_LIMIT        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MISTER_REST_MIN        = 3'd5;

   // Register reset values
   localparam logic signed [11:0] RST_TARGET_TEMPERATURE     = 12'sd250;
   localparam logic [9:0]         RST_TARGET_HUMIDITY        = 10'd600;
   localparam logic [6:0]         RST_TEMPERATURE_HYSTERESIS = 7'd5;
   localparam logic [7:0]         RST_HUMIDITY_HYSTERESIS    = 8'd30;
   localparam logic [31:0]        RST_MISTER_ON_LIMIT        = 32'd20000;
   localparam logic [31:0]        RST_MISTER_REST_MIN        = 32'd10000;

   typedef struct packed {
      logic               sensor_valid;
      logic signed [11:0] temperature;
      logic [9:0]         humidity;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic heater_on;
      logic mister_on;
      logic mister_timed_out;
   } rsp_type;

   typedef struct packed {
      logic signed [11:0] target_temperature;
      logic [9:0]         target_humidity;
      logic [6:0]         temperature_hysteresis;
      logic [7:0]         humidity_hysteresis;
      logic [31:0]        mister_on_limit;
      logic [31:0]        mister_rest_min;
   } cfg_type;

endpackage

/* hdl/hmh_csr.sv */
// Configuration register file for the heater and mister controller.
module hmh_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [hmh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hmh_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output hmh_pkg::cfg_type                   cfg
);

   hmh_pkg::cfg_type cfg_ff;
   hmh_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            hmh_pkg::CSR_TARGET_TEMPERATURE:
               cfg_in.target_temperature = $signed(csr_wdata[11:0]);
            hmh_pkg::CSR_TARGET_HUMIDITY:
               cfg_in.target_humidity = csr_wdata[9:0];
            hmh_pkg::CSR_TEMPERATURE_HYSTERESIS:
               cfg_in.temperature_hysteresis = csr_wdata[6:0];
            hmh_pkg::CSR_HUMIDITY_HYSTERESIS:
               cfg_in.humidity_hysteresis = csr_wdata[7:0];
            hmh_pkg::CSR_MISTER_ON_LIMIT:
               cfg_in.mister_on_limit = csr_wdata[31:0];
            hmh_pkg::CSR_MISTER_REST_MIN:
               cfg_in.mister_rest_min = csr_wdata[31:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temperature     <= hmh_pkg::RST_TARGET_TEMPERATURE;
         cfg_ff.target_humidity        <= hmh_pkg::RST_TARGET_HUMIDITY;
         cfg_ff.temperature_hysteresis <= hmh_pkg::RST_TEMPERATURE_HYSTERESIS;
         cfg_ff.humidity_hysteresis    <= hmh_pkg::RST_HUMIDITY_HYSTERESIS;
         cfg_ff.mister_on_limit        <= hmh_pkg::RST_MISTER_ON_LIMIT;
         cfg_ff.mister_rest_min        <= hmh_pkg::RST_MISTER_REST_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/hmh_update.sv */
// Controller state and the combinational update decision for one request.
`include "heater_mister_hysteresis_controller_macros.svh"

module hmh_update #(
   parameter int TIME_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  hmh_pkg::cfg_type cfg,
   input  hmh_pkg::req_type item,
   input  logic             advance,
   output hmh_pkg::rsp_type result
);

   localparam int CmpBits = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 heater_ff, heater_in;
   logic                 mister_ff, mister_in;
   logic [TIME_BITS-1:0] on_since_ff, on_since_in;
   logic                 on_since_valid_ff, on_since_valid_in;
   logic [TIME_BITS-1:0] off_since_ff, off_since_in;
   logic                 off_since_valid_ff, off_since_valid_in;
   logic                 timed_out;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] on_elapsed;
   logic [TIME_BITS-1:0] off_elapsed;
   logic signed [13:0]   temp_lo, temp_hi, temp_meas;
   logic signed [11:0]   hum_lo, hum_hi, hum_meas;
   logic                 over_max_on;
   logic                 past_min_off;

   assign now_t = TIME_BITS'(item.now_ms);

   // Thresholds in full signed range: no wrap below zero
   assign temp_meas = {{2{item.temperature[11]}}, item.temperature};
   assign temp_lo   = {{2{cfg.target_temperature[11]}}, cfg.target_temperature}
                      - $signed({7'd0, cfg.temperature_hysteresis});
   assign temp_hi   = {{2{cfg.target_temperature[11]}}, cfg.target_temperature}
                      + $signed({7'd0, cfg.temperature_hysteresis});
   assign hum_meas  = $signed({2'd0, item.humidity});
   assign hum_lo    = $signed({2'd0, cfg.target_humidity})
                      - $signed({4'd0, cfg.humidity_hysteresis});
   assign hum_hi    = $signed({2'd0, cfg.target_humidity})
                      + $signed({4'd0, cfg.humidity_hysteresis});

   // Timestamps latch at the first valid update that sees the new mister state
   assign on_since_in  = (mister_ff && !on_since_valid_ff) ? now_t : on_since_ff;
   assign off_since_in = (!mister_ff && !off_since_valid_ff) ? now_t : off_since_ff;
   assign on_elapsed   = now_t - on_since_in;
   assign off_elapsed  = now_t - off_since_in;
   assign over_max_on  = CmpBits'(on_elapsed) >= CmpBits'(cfg.mister_on_limit);
   assign past_min_off = CmpBits'(off_elapsed) >= CmpBits'(cfg.mister_rest_min);

   always_comb begin
      heater_in          = heater_ff;
      mister_in          = mister_ff;
      on_since_valid_in  = on_since_valid_ff;
      off_since_valid_in = off_since_valid_ff;
      timed_out          = 1'b0;
      if (!item.sensor_valid) begin
         heater_in = 1'b0;
         mister_in = 1'b0;
      end else begin
         if (!heater_ff && temp_meas <= temp_lo) begin
            heater_in = 1'b1;
         end else if (heater_ff && temp_meas >= temp_hi) begin
            heater_in = 1'b0;
         end
         on_since_valid_in  = mister_ff;
         off_since_valid_in = !mister_ff;
         if (mister_ff && over_max_on) begin
            mister_in = 1'b0;
            timed_out = 1'b1;
         end else if (!mister_ff) begin
            mister_in = past_min_off && (hum_meas <= hum_lo);
         end else begin
            mister_in = !(hum_meas >= hum_hi);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff          <= 1'b0;
         mister_ff          <= 1'b0;
         on_since_ff        <= '0;
         on_since_valid_ff  <= 1'b0;
         off_since_ff       <= '0;
         off_since_valid_ff <= 1'b1;
      end else if (advance) begin
         heater_ff <= heater_in;
         mister_ff <= mister_in;
         if (item.sensor_valid) begin
            on_since_ff        <= on_since_in;
            on_since_valid_ff  <= on_since_valid_in;
            off_since_ff       <= off_since_in;
            off_since_valid_ff <= off_since_valid_in;
         end
      end
   end

   assign result.heater_on        = heater_in;
   assign result.mister_on        = mister_in;
   assign result.mister_timed_out = timed_out;

   `HMH_ASSERT_ALWAYS(a_one_timestamp_valid, clock, reset,
      !(on_since_valid_ff && off_since_valid_ff))
   `HMH_ASSERT_NEXT(a_invalid_forces_off, clock, reset,
      advance && !item.sensor_valid, !heater_ff && !mister_ff)
   `HMH_ASSERT_NEXT(a_timeout_cuts_mister, clock, reset,
      advance && timed_out, !mister_ff && on_since_valid_ff)
   `HMH_ASSERT_NEXT(a_stall_holds_state, clock, reset,
      !advance, $stable(heater_ff) && $stable(mister_ff) && $stable(on_since_ff))

endmodule

/* hdl/heater_mister_hysteresis_controller.sv */
// Top level of the heater and mister hysteresis controller.
// One request is one sensor update; it yields exactly one response with the heater and
// mister drive and a mister timeout flag. A request is taken every cycle when the response
// side keeps up: requests land in an input register, the decision is a single pass of
// compares and TIME_BITS-wide subtractions against the controller state, and the response
// sits in an output register, so a request passes the input register and then the output
// register before its response shows on rsp_valid. The input register drains into
// the output register whenever the output is empty or being taken; a full input register
// that cannot drain is what drops req_ready. Configuration writes take effect at the
// write edge and belong between updates while the block is idle.
module heater_mister_hysteresis_controller #(
   parameter int TIME_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hmh_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hmh_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [hmh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hmh_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   hmh_pkg::cfg_type cfg;
   hmh_pkg::rsp_type result;

   logic             s1_valid_ff, s1_valid_in;
   hmh_pkg::req_type s1_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   hmh_pkg::rsp_type rsp_data_ff;
   logic             advance;

   hmh_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   hmh_update #(
      .TIME_BITS (TIME_BITS)
   ) u_update (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (s1_data_ff),
      .advance (advance),
      .result  (result)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
